// ===== rtl/mrs_pkg.sv =====
// shared types and constants for the modbus rtu slave
`timescale 1ns / 1ps
`default_nettype none
package mrs_pkg;

    localparam logic [2:0] FUNC_BYTE    = 3'd0;
    localparam logic [2:0] FUNC_WR_OUT  = 3'd1;
    localparam logic [2:0] FUNC_WR_MIN  = 3'd2;
    localparam logic [2:0] FUNC_WR_MAX  = 3'd3;
    localparam logic [2:0] FUNC_RD_IN   = 3'd4;

    localparam logic [7:0] MB_READ_HOLD = 8'd3;
    localparam logic [7:0] MB_WRITE_MUL = 8'd16;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    localparam logic [7:0] EXC_FUNC  = 8'd1;
    localparam logic [7:0] EXC_RANGE = 8'd2;
    localparam logic [7:0] EXC_VALUE = 8'd3;

    localparam logic [1:0] TBL_OUT = 2'd0;
    localparam logic [1:0] TBL_MIN = 2'd1;
    localparam logic [1:0] TBL_MAX = 2'd2;
    localparam logic [1:0] TBL_IN  = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HDR,
        ST_CRC_RD,
        ST_CRC_BIT,
        ST_CRC_CHK,
        ST_CHECK,
        ST_LIM_RD,
        ST_LIM_HI,
        ST_LIM_LO,
        ST_LIM_TBL,
        ST_LIM_CMP,
        ST_WR_HI,
        ST_WR_LO,
        ST_WR_TBL,
        ST_RSP_PREP,
        ST_RSP_RD,
        ST_RSP_BIT,
        ST_RSP_OUT,
        ST_LOCAL_RD,
        ST_LOCAL_OUT
    } state_t;

    // one bit step of reflected crc-16
    function automatic logic [15:0] crc_bit(input logic [15:0] c);
        crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mrs_regfile.sv =====
// register tables: output regs, min and max limits, input regs
`timescale 1ns / 1ps
`default_nettype none
module mrs_regfile #(
    parameter int IN_REG_COUNT  = 16,
    parameter int OUT_REG_COUNT = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         clr,
    input  wire logic [4:0]   clr_idx,
    input  wire logic         we,
    input  wire logic [1:0]   wsel,
    input  wire logic [4:0]   widx,
    input  wire logic [15:0]  wdata,
    input  wire logic [1:0]   rsel,
    input  wire logic [4:0]   ridx,
    output logic      [15:0]  rdata
);
    import mrs_pkg::*;

    localparam int OW = (OUT_REG_COUNT > 1) ? $clog2(OUT_REG_COUNT) : 1;
    localparam int IW = (IN_REG_COUNT > 1) ? $clog2(IN_REG_COUNT) : 1;

    logic [15:0] out_mem [OUT_REG_COUNT];
    logic [15:0] min_mem [IN_REG_COUNT];
    logic [15:0] max_mem [IN_REG_COUNT];
    logic [15:0] in_mem  [IN_REG_COUNT];

    // write port, clearing sweep after reset
    always_ff @(posedge clk)
    begin
        if (clr)
        begin
            if (int'(clr_idx) < OUT_REG_COUNT)
                out_mem[clr_idx[OW-1:0]] <= '0;
            if (int'(clr_idx) < IN_REG_COUNT)
            begin
                min_mem[clr_idx[IW-1:0]] <= '0;
                max_mem[clr_idx[IW-1:0]] <= '0;
                in_mem[clr_idx[IW-1:0]]  <= '0;
            end
        end
        else if (we)
        begin
            case (wsel)
                TBL_OUT: if (int'(widx) < OUT_REG_COUNT) out_mem[widx[OW-1:0]] <= wdata;
                TBL_MIN: if (int'(widx) < IN_REG_COUNT)  min_mem[widx[IW-1:0]] <= wdata;
                TBL_MAX: if (int'(widx) < IN_REG_COUNT)  max_mem[widx[IW-1:0]] <= wdata;
                default: if (int'(widx) < IN_REG_COUNT)  in_mem[widx[IW-1:0]]  <= wdata;
            endcase
        end
    end

    // registered read port, zero beyond the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rdata <= '0;
        else
        begin
            case (rsel)
                TBL_OUT: rdata <= (int'(ridx) < OUT_REG_COUNT) ? out_mem[ridx[OW-1:0]] : '0;
                TBL_MIN: rdata <= (int'(ridx) < IN_REG_COUNT)  ? min_mem[ridx[IW-1:0]] : '0;
                TBL_MAX: rdata <= (int'(ridx) < IN_REG_COUNT)  ? max_mem[ridx[IW-1:0]] : '0;
                default: rdata <= (int'(ridx) < IN_REG_COUNT)  ? in_mem[ridx[IW-1:0]]  : '0;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/modbus_rtu_slave_fc03_fc16.sv =====
// modbus rtu slave top level, functions 3 and 16
// Usage: s_axis carries one word per item: tuser = func (3 bits); tdata =
// rx_byte, reg_index, reg_value from bit 0 up; tlast = frame_last. Function 0
// words are frame bytes; at the byte with tlast the frame is checked and
// answered. m_axis gives tuser = result_kind, tdata = tx_byte then read_data
// from bit 0 up, tlast = tx_last. cfg_we/cfg_wdata set the station address.
// A local read waits for the registered table read and then for the output
// register to be free. At end of frame one shared bit-serial crc unit walks
// the buffer, then limits are checked one register at a time, then the
// registers are written; each reply byte is folded bit by bit into the crc
// before it is offered, and the two crc bytes are offered as they stand.
// After reset a clearing sweep of the tables runs over the larger table
// size while s_axis_tready stays low. When the receiver stalls the output
// word holds and the sequencer waits; no word is lost. One item is worked
// at a time.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_slave_fc03_fc16 #(
    parameter int IN_REG_COUNT  = 16,
    parameter int OUT_REG_COUNT = 16,
    parameter int BUF_BYTES     = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // rx_byte[7:0], reg_index[11:8], reg_value[27:12]
    input  wire logic [2:0]  s_axis_tuser,   // func
    input  wire logic        s_axis_tlast,   // frame_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // tx_byte[7:0], read_data[23:8]
    output logic             m_axis_tuser,   // result_kind
    output logic             m_axis_tlast    // tx_last
);
    import mrs_pkg::*;

    localparam int AW = $clog2(BUF_BYTES);
    localparam int CW = $clog2(BUF_BYTES + 1);
    localparam int MAXR = (IN_REG_COUNT > OUT_REG_COUNT) ? IN_REG_COUNT : OUT_REG_COUNT;

    logic [7:0] buf_mem [BUF_BYTES];
    logic [7:0] buf_rd_reg;

    state_t state_reg, state_next;
    logic [7:0]  addr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic ovf_reg, ovf_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [3:0]  bit_reg, bit_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  fn_reg, fn_next, b0_reg, b0_next;
    logic [16:0] low_reg, low_next, qty_reg, qty_next;
    logic [7:0]  err_reg, err_next;
    logic [16:0] k_reg, k_next;
    logic [15:0] val_reg, val_next, min_reg, min_next;
    logic [5:0]  rlen_reg, rlen_next, rk_reg, rk_next;
    logic [7:0]  rb_reg, rb_next;
    logic [4:0]  clr_reg, clr_next;
    logic [4:0]  widx_q, widx_next;
    logic [15:0] wval_q, wval_next;

    logic [7:0]  ob_reg, ob_next;
    logic [15:0] od_reg, od_next;
    logic        okind_reg, okind_next, olast_reg, olast_next, ov_reg, ov_next;

    logic        buf_we;
    logic [AW-1:0] buf_ra;
    logic        rf_we;
    logic [1:0]  rf_wsel, rf_rsel;
    logic [4:0]  rf_widx, rf_ridx;
    logic [15:0] rf_wdata, rf_rdata;

    logic [7:0]  in_byte;
    logic [4:0]  in_idx;
    logic [15:0] in_val;
    logic        accept;

    assign in_byte = s_axis_tdata[7:0];
    assign in_idx  = {1'b0, s_axis_tdata[11:8]};
    assign in_val  = s_axis_tdata[27:12];
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {od_reg, ob_reg};
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;

    // station address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            addr_reg <= 8'd1;
        else if (cfg_we)
            addr_reg <= cfg_wdata;
    end

    // frame buffer
    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[cnt_reg[AW-1:0]] <= in_byte;
        buf_rd_reg <= buf_mem[buf_ra];
    end

    mrs_regfile #(
        .IN_REG_COUNT  (IN_REG_COUNT),
        .OUT_REG_COUNT (OUT_REG_COUNT)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (state_reg == ST_CLEAR),
        .clr_idx (clr_reg),
        .we      (rf_we),
        .wsel    (rf_wsel),
        .widx    (rf_widx),
        .wdata   (rf_wdata),
        .rsel    (rf_rsel),
        .ridx    (rf_ridx),
        .rdata   (rf_rdata)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;  bit_reg <= bit_next;  crc_reg <= crc_next;
        fn_reg <= fn_next;    b0_reg <= b0_next;    low_reg <= low_next;
        qty_reg <= qty_next;  err_reg <= err_next;  k_reg <= k_next;
        val_reg <= val_next;  min_reg <= min_next;  rlen_reg <= rlen_next;
        rk_reg <= rk_next;    rb_reg <= rb_next;
        widx_q <= widx_next;  wval_q <= wval_next;
        ob_reg <= ob_next;    od_reg <= od_next;    okind_reg <= okind_next;
        olast_reg <= olast_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;   ovf_next = ovf_reg;   clr_next = clr_reg;
        ptr_next = ptr_reg;   bit_next = bit_reg;   crc_next = crc_reg;
        fn_next = fn_reg;     b0_next = b0_reg;     low_next = low_reg;
        qty_next = qty_reg;   err_next = err_reg;   k_next = k_reg;
        val_next = val_reg;   min_next = min_reg;   rlen_next = rlen_reg;
        rk_next = rk_reg;     rb_next = rb_reg;
        widx_next = widx_q;   wval_next = wval_q;
        ob_next = ob_reg;     od_next = od_reg;     okind_next = okind_reg;
        olast_next = olast_reg;
        ov_next = ov_reg && !m_axis_tready;
        buf_we = 1'b0;
        buf_ra = ptr_reg[AW-1:0];
        rf_we = 1'b0;  rf_wsel = TBL_OUT;  rf_widx = widx_q;  rf_wdata = wval_q;
        rf_rsel = TBL_OUT;  rf_ridx = widx_q;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 5'd1;
                if (int'(clr_reg) == MAXR - 1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_axis_tuser)
                        FUNC_BYTE:
                        begin
                            if (int'(cnt_reg) < BUF_BYTES)
                            begin
                                buf_we = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            else
                                ovf_next = 1'b1;
                            if (s_axis_tlast)
                            begin
                                ptr_next = '0;
                                state_next = ST_HDR;
                            end
                        end
                        FUNC_WR_OUT, FUNC_WR_MIN, FUNC_WR_MAX:
                        begin
                            rf_we = 1'b1;
                            rf_widx = in_idx;
                            rf_wdata = in_val;
                            rf_wsel = (s_axis_tuser == FUNC_WR_OUT) ? TBL_OUT :
                                      (s_axis_tuser == FUNC_WR_MIN) ? TBL_MIN : TBL_MAX;
                        end
                        FUNC_RD_IN:
                        begin
                            rf_rsel = TBL_IN;
                            rf_ridx = in_idx;
                            widx_next = in_idx;
                            state_next = ST_LOCAL_RD;
                        end
                        default: ;
                    endcase
                end
            end
            // keep the input table selected until the word is loaded
            ST_LOCAL_RD:
            begin
                rf_rsel = TBL_IN;
                state_next = ST_LOCAL_OUT;
            end
            ST_LOCAL_OUT:
            begin
                rf_rsel = TBL_IN;
                if (!ov_next)
                begin
                    ov_next = 1'b1;  okind_next = 1'b1;  ob_next = '0;
                    olast_next = 1'b0;  od_next = rf_rdata;
                    state_next = ST_IDLE;
                end
            end
            // read header bytes 0..5 one per cycle (registered buffer read)
            ST_HDR:
            begin
                if (cnt_reg < CW'(8) || ovf_reg)
                begin
                    cnt_next = '0;  ovf_next = 1'b0;  state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                    case (ptr_reg)
                        CW'(1): b0_next = buf_rd_reg;
                        CW'(2): fn_next = buf_rd_reg;
                        CW'(3): low_next = {1'b0, buf_rd_reg, 8'd0};
                        CW'(4): low_next = {1'b0, low_reg[15:8], buf_rd_reg};
                        CW'(5): qty_next = {1'b0, buf_rd_reg, 8'd0};
                        CW'(6): qty_next = {1'b0, qty_reg[15:8], buf_rd_reg};
                        default: ;
                    endcase
                    if (ptr_reg == CW'(6))
                    begin
                        ptr_next = '0;  crc_next = 16'hFFFF;  bit_next = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                err_next = '0;
                state_next = ST_CRC_RD;
                if (!(b0_reg == addr_reg || b0_reg == 8'd0))
                begin
                    cnt_next = '0;  ovf_next = 1'b0;  state_next = ST_IDLE;
                end
                else if (fn_reg == MB_READ_HOLD)
                begin
                    if (cnt_reg != CW'(8) && cnt_reg != CW'(9))
                    begin
                        cnt_next = '0;  ovf_next = 1'b0;  state_next = ST_IDLE;
                    end
                    else if (low_reg + qty_reg > 17'(OUT_REG_COUNT))
                        err_next = EXC_RANGE;
                end
                else if (fn_reg == MB_WRITE_MUL)
                begin
                    if (17'(cnt_reg) != {qty_reg[15:0], 1'b0} + 17'd9 || qty_reg[16])
                    begin
                        cnt_next = '0;  ovf_next = 1'b0;  state_next = ST_IDLE;
                    end
                    else if (low_reg + qty_reg > 17'(IN_REG_COUNT))
                        err_next = EXC_RANGE;
                end
                else
                    err_next = EXC_FUNC;
            end
            // crc over buffer bytes 0..n-3
            ST_CRC_RD:
                state_next = ST_CRC_BIT;
            ST_CRC_BIT:
            begin
                if (bit_reg == 4'd0)
                begin
                    crc_next = crc_reg ^ {8'd0, buf_rd_reg};
                    bit_next = 4'd1;
                end
                else
                begin
                    crc_next = crc_bit(crc_reg);
                    bit_next = bit_reg + 4'd1;
                    if (bit_reg == 4'd8)
                    begin
                        bit_next = '0;
                        ptr_next = ptr_reg + 1'b1;
                        state_next = (ptr_reg + 1'b1 == cnt_reg - CW'(2)) ?
                                     ST_CRC_CHK : ST_CRC_RD;
                    end
                end
            end
            ST_CRC_CHK:
            begin
                // ptr at n-2 reads low, then n-1 reads high
                if (bit_reg == 4'd0)
                begin
                    bit_next = 4'd1;
                    ptr_next = ptr_reg + 1'b1;
                end
                else if (bit_reg == 4'd1)
                begin
                    bit_next = 4'd2;
                    if (buf_rd_reg != crc_reg[7:0])
                    begin
                        bit_next = '0;  cnt_next = '0;  ovf_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    bit_next = '0;
                    k_next = '0;
                    ptr_next = CW'(7);
                    if (buf_rd_reg != crc_reg[15:8])
                    begin
                        cnt_next = '0;  ovf_next = 1'b0;  state_next = ST_IDLE;
                    end
                    else if (err_reg == 8'd0 && fn_reg == MB_WRITE_MUL)
                        state_next = ST_LIM_RD;
                    else
                        state_next = ST_RSP_PREP;
                end
            end
            // limit check: value from buffer, min and max from tables
            ST_LIM_RD:
            begin
                if (k_reg == qty_reg)
                begin
                    k_next = '0;  ptr_next = CW'(7);
                    state_next = (err_reg == 8'd0) ? ST_WR_HI : ST_RSP_PREP;
                end
                else
                    state_next = ST_LIM_HI;
            end
            ST_LIM_HI:
            begin
                ptr_next = ptr_reg + 1'b1;
                state_next = ST_LIM_LO;
            end
            ST_LIM_LO:
            begin
                val_next = {buf_rd_reg, 8'd0};
                rf_rsel = TBL_MIN;  rf_ridx = 5'(low_reg + k_reg);
                state_next = ST_LIM_TBL;
            end
            ST_LIM_TBL:
            begin
                val_next = {val_reg[15:8], buf_rd_reg};
                rf_rsel = TBL_MAX;  rf_ridx = 5'(low_reg + k_reg);
                state_next = ST_LIM_CMP;
                ptr_next = ptr_reg + 1'b1;
                min_next = rf_rdata;
            end
            ST_LIM_CMP:
            begin
                if (val_reg < min_reg || (rf_rdata != 16'd0 && val_reg > rf_rdata))
                    err_next = EXC_VALUE;
                k_next = k_reg + 17'd1;
                state_next = ST_LIM_RD;
            end
            // write input registers
            ST_WR_HI:
            begin
                if (k_reg == qty_reg)
                    state_next = ST_RSP_PREP;
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                    state_next = ST_WR_LO;
                end
            end
            ST_WR_LO:
            begin
                ptr_next = ptr_reg + 1'b1;
                wval_next = {buf_rd_reg, 8'd0};
                state_next = ST_WR_TBL;
            end
            ST_WR_TBL:
            begin
                rf_we = 1'b1;  rf_wsel = TBL_IN;
                rf_widx = 5'(low_reg + k_reg);
                rf_wdata = {wval_q[15:8], buf_rd_reg};
                k_next = k_reg + 17'd1;
                state_next = ST_WR_HI;
            end
            ST_RSP_PREP:
            begin
                cnt_next = '0;  ovf_next = 1'b0;
                crc_next = 16'hFFFF;  rk_next = '0;  bit_next = '0;
                if (b0_reg == 8'd0)
                    state_next = ST_IDLE;
                else
                begin
                    rlen_next = (err_reg != 8'd0) ? 6'd3 :
                                (fn_reg == MB_READ_HOLD) ? 6'(17'd3 + {qty_reg[15:0], 1'b0}) :
                                6'd6;
                    state_next = ST_RSP_RD;
                end
            end
            // build reply byte rk, table read for data bytes
            ST_RSP_RD:
            begin
                rf_rsel = TBL_OUT;
                rf_ridx = 5'(low_reg + 17'(rk_reg - 6'd3 >> 1));
                if (rk_reg >= rlen_reg + 6'd2)
                    state_next = ST_IDLE;
                else
                    state_next = ST_RSP_BIT;
            end
            ST_RSP_BIT:
            begin
                if (bit_reg == 4'd0)
                begin
                    if (rk_reg == rlen_reg)
                        rb_next = crc_reg[7:0];
                    else if (rk_reg == rlen_reg + 6'd1)
                        rb_next = crc_reg[15:8];
                    else if (rk_reg == 6'd0)
                        rb_next = b0_reg;
                    else if (rk_reg == 6'd1)
                        rb_next = (err_reg != 8'd0) ? (fn_reg | 8'h80) : fn_reg;
                    else if (err_reg != 8'd0)
                        rb_next = err_reg;
                    else if (fn_reg == MB_READ_HOLD)
                        rb_next = (rk_reg == 6'd2) ? 8'(qty_reg << 1) :
                                  (rk_reg[0]) ? rf_rdata[15:8] : rf_rdata[7:0];
                    else
                        case (rk_reg)
                            6'd2: rb_next = low_reg[15:8];
                            6'd3: rb_next = low_reg[7:0];
                            6'd4: rb_next = qty_reg[15:8];
                            default: rb_next = qty_reg[7:0];
                        endcase
                    bit_next = 4'd1;
                    if (rk_reg >= rlen_reg)
                        bit_next = 4'd10;
                end
                else if (bit_reg == 4'd1)
                begin
                    crc_next = crc_reg ^ {8'd0, rb_reg};
                    bit_next = 4'd2;
                end
                else if (bit_reg < 4'd10)
                begin
                    crc_next = crc_bit(crc_reg);
                    bit_next = bit_reg + 4'd1;
                end
                else
                    state_next = ST_RSP_OUT;
            end
            ST_RSP_OUT:
            begin
                if (!ov_next)
                begin
                    ov_next = 1'b1;  okind_next = 1'b0;  ob_next = rb_reg;
                    od_next = '0;
                    olast_next = (rk_reg == rlen_reg + 6'd1);
                    rk_next = rk_reg + 6'd1;
                    bit_next = '0;
                    state_next = ST_RSP_RD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire
